// File: src/rsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rsi_pkg;

  localparam int CoordW  = 32;
  localparam int DistW   = 31;
  localparam int RadW    = 31;
  localparam int ColorW  = 24;
  localparam int EpsW    = 16;
  localparam int NormW   = 18;
  localparam int CfgIdxW = 3;
  localparam int AW      = 64;
  localparam int HW      = 66;
  localparam int DiscW   = 132;
  localparam int SqW     = 66;
  localparam int SqRemW  = 134;
  localparam int LenSqW  = 68;
  localparam int LenW    = 34;
  localparam int LenRemW = 70;

  localparam logic [DistW-1:0]  DistMax = '1;
  localparam logic [CoordW-1:0] PosMax  = 32'h7fff_ffff;
  localparam logic [CoordW-1:0] NegMin  = 32'h8000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_RADIUS   = 3'd3,
    REG_COLOR    = 3'd4,
    REG_MIN_DIST = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0][CoordW-1:0] o;
    logic [2:0][CoordW-1:0] d;
  } ray_t;

  typedef struct packed {
    ray_t          ray;
    logic          miss;
    logic [AW-1:0] a;
    logic [HW-1:0] h;
  } disc_ctx_t;

  typedef struct packed {
    ray_t          ray;
    logic          miss;
    logic [AW-1:0] a;
    logic          pos_near;
    logic          pos_far;
  } div_ctx_t;

  typedef struct packed {
    logic                   hit;
    logic [DistW-1:0]       t;
    logic [2:0][CoordW-1:0] p;
    logic [2:0][CoordW:0]   n;
    logic [2:0][CoordW-1:0] d;
  } nrm_ctx_t;

endpackage

`default_nettype wire

// File: src/ray_sphere_intersect_top.sv
// Ray / sphere intersection, signed fixed point with FRAC_BITS fraction bits.
// Input channel (in_valid / in_ready) carries one ray word: origin and
// direction. Output channel (out_valid / out_ready) carries one result word:
// hit flag, distance t, hit point, unit normal facing the ray, and color.
// On a miss every result field is zero.
// The sphere (center, radius, color, min_distance) is written through the
// cfg_we / cfg_index / cfg_data port. The user must write it only while no
// ray is in flight; the block itself does not enforce this. The square roots
// work one bit per stage (66 and 34 stages), as do the restoring dividers
// (32 stages for t, FRAC_BITS + 1 for the normals). Throughput is one ray
// per cycle whenever the output word is empty or taken.
// The whole pipeline advances together: when the output word is held by a
// low out_ready, every stage holds and in_ready drops; nothing is lost.
// Reset (rst, synchronous) empties the pipeline and sets the sphere registers
// to center 0, radius 65536 (1.0 at the default), color 0, min_distance 1.
`timescale 1ns / 1ps
`default_nettype none

module ray_sphere_intersect_top
  import rsi_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic signed [CoordW-1:0]  origin_x,
  input  wire logic signed [CoordW-1:0]  origin_y,
  input  wire logic signed [CoordW-1:0]  origin_z,
  input  wire logic signed [CoordW-1:0]  dir_x,
  input  wire logic signed [CoordW-1:0]  dir_y,
  input  wire logic signed [CoordW-1:0]  dir_z,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           is_hit,
  output logic [DistW-1:0]               hit_distance,
  output logic signed [CoordW-1:0]       point_x,
  output logic signed [CoordW-1:0]       point_y,
  output logic signed [CoordW-1:0]       point_z,
  output logic signed [NormW-1:0]        normal_x,
  output logic signed [NormW-1:0]        normal_y,
  output logic signed [NormW-1:0]        normal_z,
  output logic [ColorW-1:0]              hit_color,
  input  wire logic                      cfg_we,
  input  wire logic [CfgIdxW-1:0]        cfg_index,
  input  wire logic [CoordW-1:0]         cfg_data
);

  localparam int DvW = ((67 + FRAC_BITS > 95) ? 67 + FRAC_BITS : 95) + 1;
  localparam int DvSteps = 32;
  localparam int NdW = 34 + FRAC_BITS;
  localparam int NdSteps = FRAC_BITS + 1;
  localparam int QW = (FRAC_BITS + 2 > NormW) ? FRAC_BITS + 2 : NormW;
  localparam int PrW = QW + 32;
  localparam int DotW = QW + 34;

  logic en;

  // configuration
  logic [2:0][CoordW-1:0] cen;
  logic [RadW-1:0]        radius;
  logic [ColorW-1:0]      color;
  logic [EpsW-1:0]        eps;

  always_ff @(posedge clk) begin
    if (rst) begin
      cen    <= '0;
      radius <= 31'd65536;
      color  <= '0;
      eps    <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CENTER_X: cen[0] <= cfg_data;
        REG_CENTER_Y: cen[1] <= cfg_data;
        REG_CENTER_Z: cen[2] <= cfg_data;
        REG_RADIUS:   radius <= cfg_data[RadW-1:0];
        REG_COLOR:    color  <= cfg_data[ColorW-1:0];
        REG_MIN_DIST: eps    <= cfg_data[EpsW-1:0];
        default: ;
      endcase
    end
  end

  // advance whenever the output word is empty or taken
  assign en       = ~out_valid | out_ready;
  assign in_ready = en & ~rst;

  // s1: capture ray
  logic v1;
  ray_t ray1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      ray1.o <= {origin_z, origin_y, origin_x};
      ray1.d <= {dir_z, dir_y, dir_x};
    end
  end

  // s2: oc = O - C
  logic v2;
  ray_t ray2;
  logic [2:0][CoordW:0] oc2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      ray2 <= ray1;
      for (int ax = 0; ax < 3; ax++) begin
        oc2[ax] <= {ray1.o[ax][CoordW-1], ray1.o[ax]} - {cen[ax][CoordW-1], cen[ax]};
      end
    end
  end

  // s3: products
  logic v3;
  ray_t ray3;
  logic [2:0][63:0] dd3;
  logic [2:0][64:0] od3;
  logic [2:0][65:0] oo3;
  logic [61:0]      rr3;
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      ray3 <= ray2;
      for (int ax = 0; ax < 3; ax++) begin
        dd3[ax] <= $signed(ray2.d[ax]) * $signed(ray2.d[ax]);
        od3[ax] <= $signed(oc2[ax]) * $signed(ray2.d[ax]);
        oo3[ax] <= $signed(oc2[ax]) * $signed(oc2[ax]);
      end
      rr3 <= radius * radius;
    end
  end

  // s4: a, h, c
  logic v4;
  ray_t ray4;
  logic [AW-1:0] a4;
  logic [HW-1:0] h4;
  logic [66:0]   c4;
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      ray4 <= ray3;
      a4   <= dd3[0] + dd3[1] + dd3[2];
      h4   <= {od3[0][64], od3[0]} + {od3[1][64], od3[1]} + {od3[2][64], od3[2]};
      c4   <= {2'b0, oo3[0][64:0]} + {2'b0, oo3[1][64:0]} + {2'b0, oo3[2][64:0]}
              - {5'b0, rr3};
    end
  end

  // s5: magnitudes
  logic [HW-1:0] hneg4;
  logic [66:0]   cneg4;
  assign hneg4 = -h4;
  assign cneg4 = -c4;

  logic v5;
  ray_t ray5;
  logic [AW-1:0] a5;
  logic [HW-1:0] h5;
  logic [64:0]   hm5;
  logic [65:0]   cm5;
  logic          cs5;
  logic          az5;
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
    if (en) begin
      ray5 <= ray4;
      a5   <= a4;
      h5   <= h4;
      hm5  <= h4[HW-1] ? hneg4[64:0] : h4[64:0];
      cm5  <= c4[66] ? cneg4[65:0] : c4[65:0];
      cs5  <= c4[66];
      az5  <= (a4 == '0);
    end
  end

  // s6: partial products of the 33-bit halves of |h|*|h| and a*|c|
  logic [65:0] hx5, ax5;
  assign hx5 = {1'b0, hm5};
  assign ax5 = {2'b0, a5};

  logic v6;
  ray_t ray6;
  logic [AW-1:0] a6;
  logic [HW-1:0] h6;
  logic          cs6, az6;
  logic [65:0]   phh6, phl6, pll6, pahch6, pahcl6, palch6, palcl6;
  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
    if (en) begin
      ray6   <= ray5;
      a6     <= a5;
      h6     <= h5;
      cs6    <= cs5;
      az6    <= az5;
      phh6   <= hx5[65:33] * hx5[65:33];
      phl6   <= hx5[65:33] * hx5[32:0];
      pll6   <= hx5[32:0] * hx5[32:0];
      pahch6 <= ax5[65:33] * cm5[65:33];
      pahcl6 <= ax5[65:33] * cm5[32:0];
      palch6 <= ax5[32:0] * cm5[65:33];
      palcl6 <= ax5[32:0] * cm5[32:0];
    end
  end

  // s7: recombine
  logic [66:0] acmid6;
  assign acmid6 = {1'b0, pahcl6} + {1'b0, palch6};

  logic v7;
  ray_t ray7;
  logic [AW-1:0]    a7;
  logic [HW-1:0]    h7;
  logic             cs7, az7;
  logic [DiscW-1:0] hsq7, ac7;
  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
    if (en) begin
      ray7 <= ray6;
      a7   <= a6;
      h7   <= h6;
      cs7  <= cs6;
      az7  <= az6;
      hsq7 <= {phh6, 66'b0} + {32'b0, phl6, 34'b0} + {66'b0, pll6};
      ac7  <= {pahch6, 66'b0} + {32'b0, acmid6, 33'b0} + {66'b0, palcl6};
    end
  end

  // s8: discriminant, feeds the first square root
  logic [DiscW:0] disc7;
  assign disc7 = cs7 ? {1'b0, hsq7} + {1'b0, ac7} : {1'b0, hsq7} - {1'b0, ac7};

  logic [SqW:0]       sq_v;
  disc_ctx_t          sq_ctx  [SqW+1];
  logic [SqRemW-1:0]  sq_rem  [SqW+1];
  logic [SqW-1:0]     sq_root [SqW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= v7;
    end
    if (en) begin
      sq_ctx[0].ray  <= ray7;
      sq_ctx[0].a    <= a7;
      sq_ctx[0].h    <= h7;
      sq_ctx[0].miss <= az7 | disc7[DiscW];
      sq_rem[0]      <= (az7 | disc7[DiscW]) ? '0 : {2'b0, disc7[DiscW-1:0]};
      sq_root[0]     <= '0;
    end
  end

  for (genvar k = 0; k < SqW; k++) begin : g_dsq
    localparam int B = SqW - 1 - k;
    logic [SqRemW-1:0] trial;
    assign trial = (SqRemW'(sq_root[k]) << (B + 1)) | (SqRemW'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (en) begin
        sq_v[k+1] <= sq_v[k];
      end
      if (en) begin
        sq_ctx[k+1] <= sq_ctx[k];
        if (sq_rem[k] >= trial) begin
          sq_rem[k+1]  <= sq_rem[k] - trial;
          sq_root[k+1] <= sq_root[k] | (SqW'(1) << B);
        end else begin
          sq_rem[k+1]  <= sq_rem[k];
          sq_root[k+1] <= sq_root[k];
        end
      end
    end
  end

  // root numerators, feed the t dividers
  logic [67:0] hx_r, qx_r, num_near, num_far;
  assign hx_r     = {{2{sq_ctx[SqW].h[HW-1]}}, sq_ctx[SqW].h};
  assign qx_r     = {2'b0, sq_root[SqW]};
  assign num_near = 68'd0 - hx_r - qx_r;
  assign num_far  = qx_r - hx_r;

  logic [DvSteps:0]   dv_v;
  div_ctx_t           dv_ctx   [DvSteps+1];
  logic [DvW-1:0]     dv_rem_n [DvSteps+1];
  logic [DvW-1:0]     dv_rem_f [DvSteps+1];
  logic [DistW-1:0]   dv_q_n   [DvSteps+1];
  logic [DistW-1:0]   dv_q_f   [DvSteps+1];
  logic               dv_sat_n [DvSteps+1];
  logic               dv_sat_f [DvSteps+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= sq_v[SqW];
    end
    if (en) begin
      dv_ctx[0].ray      <= sq_ctx[SqW].ray;
      dv_ctx[0].miss     <= sq_ctx[SqW].miss;
      dv_ctx[0].a        <= sq_ctx[SqW].a;
      dv_ctx[0].pos_near <= ~num_near[67] & (num_near != '0);
      dv_ctx[0].pos_far  <= ~num_far[67] & (num_far != '0);
      dv_rem_n[0]        <= DvW'(num_near[66:0]) << FRAC_BITS;
      dv_rem_f[0]        <= DvW'(num_far[66:0]) << FRAC_BITS;
      dv_q_n[0]          <= '0;
      dv_q_f[0]          <= '0;
      dv_sat_n[0]        <= 1'b0;
      dv_sat_f[0]        <= 1'b0;
    end
  end

  for (genvar j = 0; j < DvSteps; j++) begin : g_tdiv
    if (j == 0) begin : g_sat
      logic [DvW-1:0] lim;
      assign lim = DvW'(dv_ctx[0].a) << (DvSteps - 1);
      always_ff @(posedge clk) begin
        if (rst) begin
          dv_v[1] <= 1'b0;
        end else if (en) begin
          dv_v[1] <= dv_v[0];
        end
        if (en) begin
          dv_ctx[1]   <= dv_ctx[0];
          dv_rem_n[1] <= dv_rem_n[0];
          dv_rem_f[1] <= dv_rem_f[0];
          dv_q_n[1]   <= dv_q_n[0];
          dv_q_f[1]   <= dv_q_f[0];
          dv_sat_n[1] <= dv_rem_n[0] >= lim;
          dv_sat_f[1] <= dv_rem_f[0] >= lim;
        end
      end
    end else begin : g_bit
      localparam int B = DvSteps - 1 - j;
      logic [DvW-1:0] trial;
      assign trial = DvW'(dv_ctx[j].a) << B;
      always_ff @(posedge clk) begin
        if (rst) begin
          dv_v[j+1] <= 1'b0;
        end else if (en) begin
          dv_v[j+1] <= dv_v[j];
        end
        if (en) begin
          dv_ctx[j+1]   <= dv_ctx[j];
          dv_sat_n[j+1] <= dv_sat_n[j];
          dv_sat_f[j+1] <= dv_sat_f[j];
          if (dv_rem_n[j] >= trial) begin
            dv_rem_n[j+1] <= dv_rem_n[j] - trial;
            dv_q_n[j+1]   <= dv_q_n[j] | (DistW'(1) << B);
          end else begin
            dv_rem_n[j+1] <= dv_rem_n[j];
            dv_q_n[j+1]   <= dv_q_n[j];
          end
          if (dv_rem_f[j] >= trial) begin
            dv_rem_f[j+1] <= dv_rem_f[j] - trial;
            dv_q_f[j+1]   <= dv_q_f[j] | (DistW'(1) << B);
          end else begin
            dv_rem_f[j+1] <= dv_rem_f[j];
            dv_q_f[j+1]   <= dv_q_f[j];
          end
        end
      end
    end
  end

  // root select
  logic [DistW-1:0] t_near, t_far;
  logic             ok_near, ok_far;
  assign t_near  = dv_sat_n[DvSteps] ? DistMax : dv_q_n[DvSteps];
  assign t_far   = dv_sat_f[DvSteps] ? DistMax : dv_q_f[DvSteps];
  assign ok_near = dv_ctx[DvSteps].pos_near & (t_near > DistW'(eps));
  assign ok_far  = dv_ctx[DvSteps].pos_far & (t_far > DistW'(eps));

  logic vs;
  ray_t ray_s;
  logic hit_s;
  logic [DistW-1:0] t_s;
  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= 1'b0;
    end else if (en) begin
      vs <= dv_v[DvSteps];
    end
    if (en) begin
      ray_s <= dv_ctx[DvSteps].ray;
      hit_s <= ~dv_ctx[DvSteps].miss & (ok_near | ok_far);
      t_s   <= (dv_ctx[DvSteps].miss | ~(ok_near | ok_far)) ? '0 :
               (ok_near ? t_near : t_far);
    end
  end

  // p1: t * D
  logic vp1;
  ray_t ray_p1;
  logic hit_p1;
  logic [DistW-1:0] t_p1;
  logic [2:0][63:0] td_p1;
  always_ff @(posedge clk) begin
    if (rst) begin
      vp1 <= 1'b0;
    end else if (en) begin
      vp1 <= vs;
    end
    if (en) begin
      ray_p1 <= ray_s;
      hit_p1 <= hit_s;
      t_p1   <= t_s;
      for (int ax = 0; ax < 3; ax++) begin
        td_p1[ax] <= $signed({1'b0, t_s}) * $signed(ray_s.d[ax]);
      end
    end
  end

  // p2: point = O + floor(t*D / 2^F), saturated
  logic [2:0][63:0]       psum;
  logic [2:0][CoordW-1:0] psat;
  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      psum[ax] = {{32{ray_p1.o[ax][CoordW-1]}}, ray_p1.o[ax]}
                 + 64'($signed(td_p1[ax]) >>> FRAC_BITS);
      if (!psum[ax][63] && (psum[ax][62:31] != '0)) begin
        psat[ax] = PosMax;
      end else if (psum[ax][63] && !(&psum[ax][62:31])) begin
        psat[ax] = NegMin;
      end else begin
        psat[ax] = psum[ax][CoordW-1:0];
      end
    end
  end

  logic vp2;
  logic [2:0][CoordW-1:0] d_p2, p_p2;
  logic hit_p2;
  logic [DistW-1:0] t_p2;
  always_ff @(posedge clk) begin
    if (rst) begin
      vp2 <= 1'b0;
    end else if (en) begin
      vp2 <= vp1;
    end
    if (en) begin
      d_p2   <= ray_p1.d;
      p_p2   <= psat;
      hit_p2 <= hit_p1;
      t_p2   <= t_p1;
    end
  end

  // p3: P - C
  logic vp3;
  nrm_ctx_t ctx_p3;
  always_ff @(posedge clk) begin
    if (rst) begin
      vp3 <= 1'b0;
    end else if (en) begin
      vp3 <= vp2;
    end
    if (en) begin
      ctx_p3.hit <= hit_p2;
      ctx_p3.t   <= t_p2;
      ctx_p3.p   <= p_p2;
      ctx_p3.d   <= d_p2;
      for (int ax = 0; ax < 3; ax++) begin
        ctx_p3.n[ax] <= {p_p2[ax][CoordW-1], p_p2[ax]} - {cen[ax][CoordW-1], cen[ax]};
      end
    end
  end

  // p4: squares
  logic vp4;
  nrm_ctx_t ctx_p4;
  logic [2:0][65:0] nn_p4;
  always_ff @(posedge clk) begin
    if (rst) begin
      vp4 <= 1'b0;
    end else if (en) begin
      vp4 <= vp3;
    end
    if (en) begin
      ctx_p4 <= ctx_p3;
      for (int ax = 0; ax < 3; ax++) begin
        nn_p4[ax] <= $signed(ctx_p3.n[ax]) * $signed(ctx_p3.n[ax]);
      end
    end
  end

  // p5: squared length, feeds the length square root
  logic [LenW:0]        ln_v;
  nrm_ctx_t             ln_ctx  [LenW+1];
  logic [LenRemW-1:0]   ln_rem  [LenW+1];
  logic [LenW-1:0]      ln_root [LenW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      ln_v[0] <= 1'b0;
    end else if (en) begin
      ln_v[0] <= vp4;
    end
    if (en) begin
      ln_ctx[0]  <= ctx_p4;
      ln_rem[0]  <= LenRemW'({2'b0, nn_p4[0]} + {2'b0, nn_p4[1]} + {2'b0, nn_p4[2]});
      ln_root[0] <= '0;
    end
  end

  for (genvar k = 0; k < LenW; k++) begin : g_lsq
    localparam int B = LenW - 1 - k;
    logic [LenRemW-1:0] trial;
    assign trial = (LenRemW'(ln_root[k]) << (B + 1)) | (LenRemW'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (rst) begin
        ln_v[k+1] <= 1'b0;
      end else if (en) begin
        ln_v[k+1] <= ln_v[k];
      end
      if (en) begin
        ln_ctx[k+1] <= ln_ctx[k];
        if (ln_rem[k] >= trial) begin
          ln_rem[k+1]  <= ln_rem[k] - trial;
          ln_root[k+1] <= ln_root[k] | (LenW'(1) << B);
        end else begin
          ln_rem[k+1]  <= ln_rem[k];
          ln_root[k+1] <= ln_root[k];
        end
      end
    end
  end

  // normal dividers: |n| * 2^F / len
  logic [2:0][CoordW:0] nabs;
  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      nabs[ax] = ln_ctx[LenW].n[ax][CoordW] ? -ln_ctx[LenW].n[ax] : ln_ctx[LenW].n[ax];
    end
  end

  logic [NdSteps:0]          nd_v;
  nrm_ctx_t                  nd_ctx [NdSteps+1];
  logic [LenW-1:0]           nd_len [NdSteps+1];
  logic [2:0][NdW-1:0]       nd_rem [NdSteps+1];
  logic [2:0][FRAC_BITS:0]   nd_q   [NdSteps+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      nd_v[0] <= 1'b0;
    end else if (en) begin
      nd_v[0] <= ln_v[LenW];
    end
    if (en) begin
      nd_ctx[0] <= ln_ctx[LenW];
      nd_len[0] <= ln_root[LenW];
      nd_q[0]   <= '0;
      for (int ax = 0; ax < 3; ax++) begin
        nd_rem[0][ax] <= NdW'(nabs[ax]) << FRAC_BITS;
      end
    end
  end

  for (genvar j = 0; j < NdSteps; j++) begin : g_ndiv
    localparam int B = NdSteps - 1 - j;
    logic [NdW-1:0] trial;
    assign trial = NdW'(nd_len[j]) << B;
    always_ff @(posedge clk) begin
      if (rst) begin
        nd_v[j+1] <= 1'b0;
      end else if (en) begin
        nd_v[j+1] <= nd_v[j];
      end
      if (en) begin
        nd_ctx[j+1] <= nd_ctx[j];
        nd_len[j+1] <= nd_len[j];
        for (int ax = 0; ax < 3; ax++) begin
          if (nd_rem[j][ax] >= trial) begin
            nd_rem[j+1][ax] <= nd_rem[j][ax] - trial;
            nd_q[j+1][ax]   <= nd_q[j][ax] | ((FRAC_BITS + 1)'(1) << B);
          end else begin
            nd_rem[j+1][ax] <= nd_rem[j][ax];
            nd_q[j+1][ax]   <= nd_q[j][ax];
          end
        end
      end
    end
  end

  // f0: signed normal
  logic vf0;
  nrm_ctx_t ctx_f0;
  logic [2:0][QW-1:0] qs_f0;
  always_ff @(posedge clk) begin
    if (rst) begin
      vf0 <= 1'b0;
    end else if (en) begin
      vf0 <= nd_v[NdSteps];
    end
    if (en) begin
      ctx_f0 <= nd_ctx[NdSteps];
      for (int ax = 0; ax < 3; ax++) begin
        if (nd_len[NdSteps] == '0) begin
          qs_f0[ax] <= '0;
        end else if (nd_ctx[NdSteps].n[ax][CoordW]) begin
          qs_f0[ax] <= -QW'(nd_q[NdSteps][ax]);
        end else begin
          qs_f0[ax] <= QW'(nd_q[NdSteps][ax]);
        end
      end
    end
  end

  // f1: normal . D products
  logic vf1;
  nrm_ctx_t ctx_f1;
  logic [2:0][QW-1:0]  qs_f1;
  logic [2:0][PrW-1:0] pr_f1;
  always_ff @(posedge clk) begin
    if (rst) begin
      vf1 <= 1'b0;
    end else if (en) begin
      vf1 <= vf0;
    end
    if (en) begin
      ctx_f1 <= ctx_f0;
      qs_f1  <= qs_f0;
      for (int ax = 0; ax < 3; ax++) begin
        pr_f1[ax] <= $signed(qs_f0[ax]) * $signed(ctx_f0.d[ax]);
      end
    end
  end

  // f2: facing test
  logic [DotW-1:0] dot_f1;
  assign dot_f1 = {{2{pr_f1[0][PrW-1]}}, pr_f1[0]} + {{2{pr_f1[1][PrW-1]}}, pr_f1[1]}
                  + {{2{pr_f1[2][PrW-1]}}, pr_f1[2]};

  logic vf2;
  nrm_ctx_t ctx_f2;
  logic [2:0][QW-1:0] qs_f2;
  logic flip_f2;
  always_ff @(posedge clk) begin
    if (rst) begin
      vf2 <= 1'b0;
    end else if (en) begin
      vf2 <= vf1;
    end
    if (en) begin
      ctx_f2  <= ctx_f1;
      qs_f2   <= qs_f1;
      flip_f2 <= ~dot_f1[DotW-1] & (dot_f1 != '0);
    end
  end

  // output word
  logic [2:0][QW-1:0] nrm_o;
  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      nrm_o[ax] = flip_f2 ? -qs_f2[ax] : qs_f2[ax];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vf2;
    end
    if (en) begin
      is_hit       <= ctx_f2.hit;
      hit_distance <= ctx_f2.hit ? ctx_f2.t : '0;
      point_x      <= ctx_f2.hit ? ctx_f2.p[0] : '0;
      point_y      <= ctx_f2.hit ? ctx_f2.p[1] : '0;
      point_z      <= ctx_f2.hit ? ctx_f2.p[2] : '0;
      normal_x     <= ctx_f2.hit ? nrm_o[0][NormW-1:0] : '0;
      normal_y     <= ctx_f2.hit ? nrm_o[1][NormW-1:0] : '0;
      normal_z     <= ctx_f2.hit ? nrm_o[2][NormW-1:0] : '0;
      hit_color    <= ctx_f2.hit ? color : '0;
    end
  end

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_hit |-> hit_distance == '0 && hit_color == '0 && point_x == '0
      && normal_x == '0)
    else $error("miss word carries nonzero fields");

  a_hit_beyond_eps: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_hit |-> hit_distance > DistW'(eps))
    else $error("hit distance not beyond min_distance");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sq_v) && $stable(ln_v)
      && $stable(hit_distance))
    else $error("pipeline moved while output stalled");

endmodule

`default_nettype wire

// File: verif/ray_sphere_intersect_top_tb.sv
`timescale 1ns / 1ps

module ray_sphere_intersect_top_tb
  import rsi_pkg::*;
();

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic signed [31:0] ox, oy, oz, dx, dy, dz;
  } ray_word_t;

  typedef struct {
    logic              hit;
    logic [30:0]       t;
    logic signed [31:0] px, py, pz;
    logic [17:0]       nx, ny, nz;
    logic [23:0]       color;
  } hit_word_t;

  localparam int LatencyCycles = 169;
  localparam int CycleLimit    = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] origin_x = '0, origin_y = '0, origin_z = '0;
  logic signed [31:0] dir_x = '0, dir_y = '0, dir_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic is_hit;
  logic [DistW-1:0] hit_distance;
  logic signed [CoordW-1:0] point_x, point_y, point_z;
  logic signed [NormW-1:0] normal_x, normal_y, normal_z;
  logic [ColorW-1:0] hit_color;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CoordW-1:0] cfg_data = '0;

  logic signed [31:0] sph_cx = 0, sph_cy = 0, sph_cz = 0;
  logic [30:0] sph_r = 31'd65536;
  logic [23:0] sph_color = '0;
  logic [15:0] sph_eps = 16'd1;

  ray_word_t pending_rays[$];
  hit_word_t expected_hits[$];
  int errors = 0;
  int cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;
  bit steady = 1'b0;
  bit hold_sender = 1'b0;

  ray_sphere_intersect_top dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic wide_t isqrt(wide_t x);
    wide_t r, c;
    r = '0;
    for (int i = 70; i >= 0; i--) begin
      c = r | (wide_t'(1) << i);
      if (c * c <= x) r = c;
    end
    return r;
  endfunction

  function automatic logic [30:0] root_to_t(wide_t num, wide_t a);
    wide_t q;
    q = (num <<< 16) / a;
    if (q >= (wide_t'(1) << 31)) return 31'h7fff_ffff;
    return q[30:0];
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unit_comp(longint n, longint len);
    longint m, q;
    m = n < 0 ? -n : n;
    q = (m <<< 16) / len;
    return n < 0 ? -q : q;
  endfunction

  function automatic hit_word_t trace_ray(ray_word_t r);
    hit_word_t w;
    wide_t dx, dy, dz, cx, cy, cz, a, h, c, disc, q, num;
    logic [30:0] t;
    longint px, py, pz, nx, ny, nz, len, mx, my, mz;
    w = '{default: '0};
    dx = r.dx; dy = r.dy; dz = r.dz;
    cx = wide_t'(r.ox) - wide_t'(sph_cx);
    cy = wide_t'(r.oy) - wide_t'(sph_cy);
    cz = wide_t'(r.oz) - wide_t'(sph_cz);
    a = dx * dx + dy * dy + dz * dz;
    if (a == 0) return w;
    h = cx * dx + cy * dy + cz * dz;
    c = cx * cx + cy * cy + cz * cz - wide_t'({1'b0, sph_r}) * wide_t'({1'b0, sph_r});
    disc = h * h - a * c;
    if (disc < 0) return w;
    q = isqrt(disc);
    num = -h - q;
    if (num > 0) begin
      t = root_to_t(num, a);
      w.hit = t > sph_eps;
    end
    if (!w.hit) begin
      num = -h + q;
      if (num > 0) begin
        t = root_to_t(num, a);
        w.hit = t > sph_eps;
      end
    end
    if (!w.hit) return w;
    px = sat32(longint'(r.ox) + ((longint'(t) * longint'(r.dx)) >>> 16));
    py = sat32(longint'(r.oy) + ((longint'(t) * longint'(r.dy)) >>> 16));
    pz = sat32(longint'(r.oz) + ((longint'(t) * longint'(r.dz)) >>> 16));
    nx = px - sph_cx;
    ny = py - sph_cy;
    nz = pz - sph_cz;
    len = longint'(isqrt(wide_t'(nx) * nx + wide_t'(ny) * ny + wide_t'(nz) * nz));
    mx = 0; my = 0; mz = 0;
    if (len != 0) begin
      mx = unit_comp(nx, len);
      my = unit_comp(ny, len);
      mz = unit_comp(nz, len);
      if (mx * r.dx + my * r.dy + mz * r.dz > 0) begin
        mx = -mx; my = -my; mz = -mz;
      end
    end
    w.t = t;
    w.px = px[31:0]; w.py = py[31:0]; w.pz = pz[31:0];
    w.nx = mx[17:0]; w.ny = my[17:0]; w.nz = mz[17:0];
    w.color = sph_color;
    return w;
  endfunction

  function automatic int pick_gap();
    int k;
    if (steady) return 0;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  always @(posedge clk) begin
    ray_word_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_ready)) begin
      if (in_valid) expected_hits.push_back(trace_ray('{origin_x, origin_y, origin_z,
                                                        dir_x, dir_y, dir_z}));
      if (send_gap > 0 || hold_sender || pending_rays.size() == 0) begin
        in_valid <= 1'b0;
        if (send_gap > 0) send_gap <= send_gap - 1;
      end else begin
        r = pending_rays.pop_front();
        origin_x <= r.ox; origin_y <= r.oy; origin_z <= r.oz;
        dir_x <= r.dx; dir_y <= r.dy; dir_z <= r.dz;
        in_valid <= 1'b1;
        send_gap <= pick_gap();
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    hit_word_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_hits.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          e = expected_hits.pop_front();
          if (is_hit !== e.hit) begin
            $error("is_hit exp %0d got %0d", e.hit, is_hit); errors++;
          end
          if (hit_distance !== e.t) begin
            $error("hit_distance exp %0d got %0d", e.t, hit_distance); errors++;
          end
          if (point_x !== e.px) begin
            $error("point_x exp %0d got %0d", e.px, point_x); errors++;
          end
          if (point_y !== e.py) begin
            $error("point_y exp %0d got %0d", e.py, point_y); errors++;
          end
          if (point_z !== e.pz) begin
            $error("point_z exp %0d got %0d", e.pz, point_z); errors++;
          end
          if (normal_x !== e.nx) begin
            $error("normal_x exp %0h got %0h", e.nx, normal_x); errors++;
          end
          if (normal_y !== e.ny) begin
            $error("normal_y exp %0h got %0h", e.ny, normal_y); errors++;
          end
          if (normal_z !== e.nz) begin
            $error("normal_z exp %0h got %0h", e.nz, normal_z); errors++;
          end
          if (hit_color !== e.color) begin
            $error("hit_color exp %0h got %0h", e.color, hit_color); errors++;
          end
        end
      end
      if (recv_gap > 0) begin
        out_ready <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else begin
        out_ready <= 1'b1;
        recv_gap <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("FAIL ray_sphere_intersect_top");
      $finish;
    end
  end

  task automatic add_ray(logic signed [31:0] ox, oy, oz, dx, dy, dz);
    pending_rays.push_back('{ox, oy, oz, dx, dy, dz});
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_CENTER_X: sph_cx = val;
      REG_CENTER_Y: sph_cy = val;
      REG_CENTER_Z: sph_cz = val;
      REG_RADIUS:   sph_r = val[30:0];
      REG_COLOR:    sph_color = val[23:0];
      REG_MIN_DIST: sph_eps = val[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_rays.size() != 0 || in_valid || expected_hits.size() != 0);
    repeat (LatencyCycles / 8) @(posedge clk);
  endtask

  task automatic set_sphere(logic [31:0] cx, cy, cz, r, col, eps);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_RADIUS, r);
    write_reg(REG_COLOR, col);
    write_reg(REG_MIN_DIST, eps);
  endtask

  function automatic logic signed [31:0] jitter(int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  // aim at a random point near the sphere, from a random origin around it
  task automatic add_aimed_ray();
    logic signed [31:0] ox, oy, oz, tx, ty, tz;
    int span;
    int sh;
    span = (sph_r < 31'd4194304) ? sph_r + 1 : 4194304;
    ox = sph_cx + jitter(8 * span); oy = sph_cy + jitter(8 * span);
    oz = sph_cz + jitter(8 * span);
    tx = sph_cx + jitter(span); ty = sph_cy + jitter(span); tz = sph_cz + jitter(span);
    sh = $urandom_range(0, 3);
    add_ray(ox, oy, oz, (tx - ox) >>> sh, (ty - oy) >>> sh, (tz - oz) >>> sh);
  endtask

  task automatic add_random_ray();
    add_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset sphere: unit radius at the origin
    add_ray(-32'sh30000, 0, 0, 32'sh10000, 0, 0);
    add_ray(-32'sh30000, 0, 0, 0, 0, 0);
    add_ray(-32'sh30000, 32'sh20000, 0, 32'sh10000, 0, 0);
    add_ray(-32'sh30000, 32'sh10000, 0, 32'sh10000, 0, 0);
    add_ray(0, 0, 0, 0, 32'sh10000, 0);
    add_ray(32'sh4000, 0, 0, 0, 0, -32'sh10000);
    add_ray(32'sh30000, 0, 0, 32'sh10000, 0, 0);
    add_ray(-32'sh7fffffff - 1, 0, 0, 1, 0, 0);
    add_ray(-32'sh7fffffff - 1, 0, 0, 32'sh7fffffff, 0, 0);
    add_ray(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
            -32'sh7fffffff - 1, -32'sh7fffffff - 1, -32'sh7fffffff - 1);
    add_ray(-32'sh7fffffff - 1, -32'sh7fffffff - 1, -32'sh7fffffff - 1,
            32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    add_ray(0, 32'sh7fffffff, 0, 32'sh7fffffff, -32'sh7fffffff - 1, 0);
    add_ray(-32'sh20000, 0, 0, 32'sh7fffffff, 32'sh7fffffff, 0);
    add_ray(-32'sh10000, 0, 0, 1, 0, 0);
    drain();

    // zero radius: hit lands on the center, normal collapses
    set_sphere(32'h0001_8000, 32'hffff_0000, 32'h0002_0000, 0, 24'hffffff, 0);
    add_ray(32'h0000_8000, 32'hffff_0000, 32'h0002_0000, 32'sh10000, 0, 0);
    add_ray(32'h0000_8000, 32'hffff_0000, 32'h0002_0000, 32'sh1000, 0, 0);
    add_ray(32'h0000_8000, 32'hffff_8000, 32'h0002_0000, 32'sh10000, 0, 0);
    for (int i = 0; i < 20; i++) add_aimed_ray();
    drain();

    // extreme center, huge radius, widest epsilon
    set_sphere(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 24'h123456, 16'hffff);
    add_ray(0, 0, 0, 32'sh10000, 0, 0);
    add_ray(0, 0, 0, 0, 0, 32'sh7fffffff);
    for (int i = 0; i < 30; i++) add_random_ray();
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      set_sphere(jitter(1 << (4 + 3 * phase)), jitter(1 << (4 + 3 * phase)),
                 jitter(1 << (4 + 3 * phase)),
                 phase == 7 ? 32'h7fff_ffff : $urandom_range(1, 1 << (10 + 2 * phase)),
                 $urandom, phase == 0 ? 16'hffff : (phase == 1 ? 0 : $urandom_range(0, 300)));
      steady = (phase % 3 == 2);
      for (int i = 0; i < 145; i++) begin
        if ($urandom_range(0, 9) < 8) add_aimed_ray();
        else add_random_ray();
        if (phase == 3 && i == 70) begin
          while (pending_rays.size() != 0) @(posedge clk);
          hold_sender = 1'b1;
          while (in_valid || expected_hits.size() != 0) @(posedge clk);
          hold_sender = 1'b0;
        end
      end
      drain();
    end
    steady = 1'b0;

    repeat (LatencyCycles * 2) @(posedge clk);
    if (errors == 0) begin
      $display("PASS ray_sphere_intersect_top");
    end else begin
      $display("FAIL ray_sphere_intersect_top");
    end
    $finish;
  end

endmodule
